// ----- sv/rspu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspu_pkg: shared types and microcode for the range sum / point update tree
// holds sizes, item codes, control word layout and the sequencer program
// ----------------------------------------------------------------------------
package rspu_pkg;

  // tree geometry
  localparam int LEAF_COUNT = 1024;
  localparam int TREE_DEPTH = 2 * LEAF_COUNT;
  localparam int ADDR_W     = $clog2(TREE_DEPTH);
  localparam int POS_W      = ADDR_W + 1;

  // item field widths
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int DATA_W  = 64;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  // item kinds
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // program steps
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_CLR   = 3'd0;
  localparam step_t S_IDLE  = 3'd1;
  localparam step_t S_UW    = 3'd2;
  localparam step_t S_URD   = 3'd3;
  localparam step_t S_UADD  = 3'd4;
  localparam step_t S_QA    = 3'd5;
  localparam step_t S_QB    = 3'd6;
  localparam step_t S_EMIT  = 3'd7;

  // datapath actions
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ACCEPT,
    OP_LEAF_WR,
    OP_SIB_RD,
    OP_PARENT_WR,
    OP_Q_LEFT,
    OP_Q_RIGHT,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_A_LE1,
    C_A_GE_B,
    C_CLR_MORE,
    C_DISPATCH
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_word_t;

  // read-only program, one control word per step
  function automatic ucode_word_t ucode(input step_t s);
    ucode_word_t w;
    unique case (s)
      S_CLR:  w = '{op: OP_CLEAR,     cond: C_CLR_MORE, target: S_CLR};
      S_IDLE: w = '{op: OP_ACCEPT,    cond: C_DISPATCH, target: S_IDLE};
      S_UW:   w = '{op: OP_LEAF_WR,   cond: C_NONE,     target: S_URD};
      S_URD:  w = '{op: OP_SIB_RD,    cond: C_A_LE1,    target: S_IDLE};
      S_UADD: w = '{op: OP_PARENT_WR, cond: C_ALWAYS,   target: S_URD};
      S_QA:   w = '{op: OP_Q_LEFT,    cond: C_A_GE_B,   target: S_EMIT};
      S_QB:   w = '{op: OP_Q_RIGHT,   cond: C_ALWAYS,   target: S_QA};
      S_EMIT: w = '{op: OP_EMIT,      cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/rspu_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspu_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rspu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/range_sum_point_update_tree_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sum_point_update_tree_top: segment tree of wrapped 64-bit sums
// point updates and inclusive range sum queries over 1024 leaves
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the 2048-word tree store to zero, one
// word a cycle, and holds busy high throughout the sweep; element_count may
// still be written then. An item is taken when start is high and busy is low.
// kind 0 writes new_value to leaf index_low, then rebuilds its ancestors by
// reading each sibling and writing the parent, level by level; an update at or
// beyond the element count is dropped and gives no result. kind 1 sums
// leaves index_low..index_high (high clamped to count-1) and raises
// result_valid for exactly one cycle with range_sum; it climbs the tree one
// level at a time, and an empty range goes straight to the result.
// The pace is set by the single read port of the tree store: every node
// visited costs one read and one add. Results cannot be held off, so sample
// range_sum whenever result_valid is high. Write element_count only while
// busy is low.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree_top (
  input  logic                               clk,
  input  logic                               rst,
  // item port
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [rspu_pkg::INDEX_W-1:0]       index_low,
  input  logic [rspu_pkg::INDEX_W-1:0]       index_high,
  input  logic signed [rspu_pkg::DATA_W-1:0] new_value,
  // result port
  output logic                               result_valid,
  output logic signed [rspu_pkg::DATA_W-1:0] range_sum,
  // configuration port
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rspu_pkg::COUNT_W-1:0]       cfg_element_count
);

  // sequencer
  rspu_pkg::step_t       step;
  rspu_pkg::step_t       step_next;
  rspu_pkg::step_t       step_inc;
  rspu_pkg::ucode_word_t uw;

  // datapath registers
  logic [rspu_pkg::POS_W-1:0]   a, a_next;     // left cursor, also clear pointer
  logic [rspu_pkg::POS_W-1:0]   b, b_next;     // right cursor, exclusive
  logic [rspu_pkg::DATA_W-1:0]  acc, acc_next; // query accumulator
  logic [rspu_pkg::DATA_W-1:0]  cur, cur_next; // running sum up the update path
  logic                         a_hit, a_hit_next;
  logic                         b_hit, b_hit_next;
  logic [rspu_pkg::COUNT_W-1:0] element_count;
  logic                         emit;

  // item decode
  logic                         accept;
  logic [rspu_pkg::COUNT_W-1:0] count_eff;
  logic [rspu_pkg::COUNT_W-1:0] last_leaf;
  logic [rspu_pkg::COUNT_W-1:0] hi_clamped;
  logic                         upd_ok;
  logic                         q_empty;

  // tree store access
  logic                          ram_wr_en;
  logic [rspu_pkg::ADDR_W-1:0]   ram_wr_addr;
  logic [rspu_pkg::DATA_W-1:0]   ram_wr_data;
  logic [rspu_pkg::ADDR_W-1:0]   ram_rd_addr;
  logic [rspu_pkg::DATA_W-1:0]   ram_rd_data;
  logic [rspu_pkg::DATA_W-1:0]   parent_sum;
  logic [rspu_pkg::POS_W-1:0]    a_half;

  assign busy      = (step != rspu_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign uw        = rspu_pkg::ucode(step);
  assign step_inc  = step + rspu_pkg::STEP_W'(1);

  // counts above the leaf count behave as the leaf count
  assign count_eff  = (int'(element_count) > rspu_pkg::LEAF_COUNT)
                    ? rspu_pkg::COUNT_W'(rspu_pkg::LEAF_COUNT) : element_count;
  assign last_leaf  = count_eff - rspu_pkg::COUNT_W'(1);
  assign hi_clamped = (rspu_pkg::COUNT_W'(index_high) > last_leaf)
                    ? last_leaf : rspu_pkg::COUNT_W'(index_high);
  assign upd_ok     = rspu_pkg::COUNT_W'(index_low) < count_eff;
  // zero count or low above the clamped high gives an empty range
  assign q_empty    = (count_eff == '0) || (rspu_pkg::COUNT_W'(index_low) > hi_clamped);

  assign parent_sum = cur + ram_rd_data;
  assign a_half     = a >> 1;

  // next step: fall through, or jump on the word's condition
  always_comb begin
    step_next = step_inc;
    unique case (uw.cond)
      rspu_pkg::C_NONE:     step_next = step_inc;
      rspu_pkg::C_ALWAYS:   step_next = uw.target;
      rspu_pkg::C_A_LE1:    step_next = (a <= rspu_pkg::POS_W'(1)) ? uw.target : step_inc;
      rspu_pkg::C_A_GE_B:   step_next = (a >= b) ? uw.target : step_inc;
      rspu_pkg::C_CLR_MORE: step_next = (a != rspu_pkg::POS_W'(rspu_pkg::TREE_DEPTH - 1))
                                      ? uw.target : step_inc;
      rspu_pkg::C_DISPATCH: begin
        if (!accept) begin
          step_next = rspu_pkg::S_IDLE;
        end else if (kind == rspu_pkg::KIND_UPDATE) begin
          step_next = upd_ok ? rspu_pkg::S_UW : rspu_pkg::S_IDLE;
        end else begin
          step_next = q_empty ? rspu_pkg::S_EMIT : rspu_pkg::S_QA;
        end
      end
      default: step_next = rspu_pkg::S_IDLE;
    endcase
  end

  // datapath driven by the current control word
  always_comb begin
    a_next      = a;
    b_next      = b;
    acc_next    = acc;
    cur_next    = cur;
    a_hit_next  = a_hit;
    b_hit_next  = b_hit;
    emit        = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = a[rspu_pkg::ADDR_W-1:0];
    ram_wr_data = cur;
    ram_rd_addr = a[rspu_pkg::ADDR_W-1:0];
    unique case (uw.op)
      rspu_pkg::OP_CLEAR: begin
        // zeroing sweep after reset
        ram_wr_en   = 1'b1;
        ram_wr_data = '0;
        a_next      = a + rspu_pkg::POS_W'(1);
      end
      rspu_pkg::OP_ACCEPT: begin
        if (accept) begin
          a_next     = rspu_pkg::POS_W'(index_low) + rspu_pkg::POS_W'(rspu_pkg::LEAF_COUNT);
          b_next     = rspu_pkg::POS_W'(hi_clamped) + rspu_pkg::POS_W'(rspu_pkg::LEAF_COUNT)
                     + rspu_pkg::POS_W'(1);
          acc_next   = '0;
          cur_next   = new_value;
          a_hit_next = 1'b0;
          b_hit_next = 1'b0;
        end
      end
      rspu_pkg::OP_LEAF_WR: begin
        ram_wr_en = 1'b1;
      end
      rspu_pkg::OP_SIB_RD: begin
        ram_rd_addr = a[rspu_pkg::ADDR_W-1:0] ^ rspu_pkg::ADDR_W'(1);
      end
      rspu_pkg::OP_PARENT_WR: begin
        // sibling data is back, write the parent
        ram_wr_en   = 1'b1;
        ram_wr_addr = a_half[rspu_pkg::ADDR_W-1:0];
        ram_wr_data = parent_sum;
        cur_next    = parent_sum;
        a_next      = a_half;
      end
      rspu_pkg::OP_Q_LEFT: begin
        // fold the pending right node, fetch the left node if odd
        if (b_hit) begin
          acc_next = acc + ram_rd_data;
        end
        b_hit_next = 1'b0;
        a_hit_next = a[0];
        if (a[0]) begin
          a_next = a + rspu_pkg::POS_W'(1);
        end
      end
      rspu_pkg::OP_Q_RIGHT: begin
        // fold the left node, fetch b-1 if b odd, climb one level
        if (a_hit) begin
          acc_next = acc + ram_rd_data;
        end
        a_hit_next  = 1'b0;
        b_hit_next  = b[0];
        ram_rd_addr = {b[rspu_pkg::ADDR_W-1:1], 1'b0};
        a_next      = a_half;
        b_next      = b >> 1;
      end
      rspu_pkg::OP_EMIT: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= rspu_pkg::S_CLR;
      a             <= '0;
      a_hit         <= 1'b0;
      b_hit         <= 1'b0;
      result_valid  <= 1'b0;
      element_count <= rspu_pkg::COUNT_RESET;
    end else begin
      step         <= step_next;
      a            <= a_next;
      a_hit        <= a_hit_next;
      b_hit        <= b_hit_next;
      result_valid <= emit;
      if (cfg_valid && cfg_ready) begin
        element_count <= cfg_element_count;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    b   <= b_next;
    acc <= acc_next;
    cur <= cur_next;
    if (emit) begin
      range_sum <= acc;
    end
  end

  rspu_ram #(
    .WIDTH (rspu_pkg::DATA_W),
    .DEPTH (rspu_pkg::TREE_DEPTH)
  ) u_tree (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

`ifndef NO_ASSERTIONS
  // a result only ever follows the emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(step) == rspu_pkg::S_EMIT)
    else $error("result strobe without emit step");

  // queries never disturb the tree store
  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (step == rspu_pkg::S_QA || step == rspu_pkg::S_QB) |-> !ram_wr_en)
    else $error("tree write during query");

  // right cursor stays within the store while the query climbs
  a_query_bound: assert property (@(posedge clk) disable iff (rst)
    (step == rspu_pkg::S_QA) |-> b <= rspu_pkg::POS_W'(rspu_pkg::TREE_DEPTH))
    else $error("query cursor past tree end");

  // the zeroing sweep hands over to idle, never to a working step
  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    (step == rspu_pkg::S_CLR && step_next != rspu_pkg::S_CLR)
      |=> step == rspu_pkg::S_IDLE && !result_valid)
    else $error("clear sweep left to wrong step");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the range sum / point update tree
// drives a table of directed items and then phases of random items under
// several element counts; a sum tree kept in the bench predicts each range
// sum, and every strobed result is compared with the oldest expected sum,
// which is the hand-typed answer where a directed item has one
module testbench;

  // one item on the command port, with an optional hand-typed answer
  typedef struct {
    logic                         kind;
    logic [rspu_pkg::INDEX_W-1:0] lo;
    logic [rspu_pkg::INDEX_W-1:0] hi;
    logic [rspu_pkg::DATA_W-1:0]  value;
    bit                           typed;
    logic [rspu_pkg::DATA_W-1:0]  want;
  } sum_item_t;

  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_TICKS = 40;   // longer than the slowest item
  localparam int PHASE_ITEMS  = 125;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                start = 1'b0;
  logic                                busy;
  logic                                kind = rspu_pkg::KIND_UPDATE;
  logic [rspu_pkg::INDEX_W-1:0]        index_low = '0;
  logic [rspu_pkg::INDEX_W-1:0]        index_high = '0;
  logic signed [rspu_pkg::DATA_W-1:0]  new_value = '0;
  logic                                result_valid;
  logic signed [rspu_pkg::DATA_W-1:0]  range_sum;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [rspu_pkg::COUNT_W-1:0]        cfg_element_count = rspu_pkg::COUNT_RESET;

  // bench copy of the tree and of the element count
  logic [rspu_pkg::DATA_W-1:0]  sum_tree [0:rspu_pkg::TREE_DEPTH-1];
  logic [rspu_pkg::COUNT_W-1:0] model_count;

  // range sums still to come out of the block, oldest first
  logic [rspu_pkg::DATA_W-1:0] pending_sums [$];
  int                          fail_count = 0;

  sum_item_t directed_rows [$];

  range_sum_point_update_tree_top uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .kind              (kind),
    .index_low         (index_low),
    .index_high        (index_high),
    .new_value         (new_value),
    .result_valid      (result_valid),
    .range_sum         (range_sum),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_element_count (cfg_element_count)
  );

  always #1 clk = ~clk;

  // write one leaf and rebuild every ancestor on the way to the root
  function automatic void tree_point_write(input int leaf,
                                           input logic [rspu_pkg::DATA_W-1:0] v);
    int pos;
    pos = leaf + rspu_pkg::LEAF_COUNT;
    sum_tree[pos] = v;
    while (pos > 1) begin
      sum_tree[pos >> 1] = sum_tree[pos] + sum_tree[pos ^ 1];
      pos = pos >> 1;
    end
  endfunction

  // bottom-up walk over the inclusive leaf span, sums wrap at 64 bits
  function automatic logic [rspu_pkg::DATA_W-1:0] tree_span_sum(input int lo, input int hi);
    logic [rspu_pkg::DATA_W-1:0] acc;
    int a;
    int b;
    acc = '0;
    a = lo + rspu_pkg::LEAF_COUNT;
    b = hi + rspu_pkg::LEAF_COUNT + 1;
    while (a < b) begin
      if (a & 1) begin
        acc = acc + sum_tree[a];
        a = a + 1;
      end
      if (b & 1) begin
        b = b - 1;
        acc = acc + sum_tree[b];
      end
      a = a >> 1;
      b = b >> 1;
    end
    return acc;
  endfunction

  // apply one item to the bench tree; returns 1 when it yields a range sum
  function automatic bit tree_apply(input sum_item_t it,
                                    output logic [rspu_pkg::DATA_W-1:0] sum);
    int eff;
    int hi;
    eff = (model_count > rspu_pkg::LEAF_COUNT) ? rspu_pkg::LEAF_COUNT : int'(model_count);
    sum = '0;
    if (it.kind == rspu_pkg::KIND_UPDATE) begin
      if (int'(it.lo) < eff) tree_point_write(int'(it.lo), it.value);
      return 1'b0;
    end
    // a count of zero answers every query with 0
    if (eff == 0) return 1'b1;
    hi = (int'(it.hi) > eff - 1) ? eff - 1 : int'(it.hi);
    if (int'(it.lo) <= hi) sum = tree_span_sum(int'(it.lo), hi);
    return 1'b1;
  endfunction

  function automatic logic [rspu_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 64'h7FFF_FFFF_FFFF_FFFF;
      1:       return 64'h8000_0000_0000_0000;
      2:       return rspu_pkg::DATA_W'(signed'($urandom_range(0, 64)) - 32);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly spans inside the active leaves, the rest anywhere in the index range
  function automatic sum_item_t random_item(input int eff);
    sum_item_t it;
    int a;
    int b;
    it.typed = 1'b0;
    it.want  = '0;
    it.kind  = ($urandom_range(0, 1) == 0) ? rspu_pkg::KIND_UPDATE : rspu_pkg::KIND_QUERY;
    it.value = random_value();
    it.lo    = rspu_pkg::INDEX_W'($urandom);
    it.hi    = rspu_pkg::INDEX_W'($urandom);
    if (eff > 0 && $urandom_range(0, 3) != 0) begin
      a = $urandom_range(0, eff - 1);
      b = $urandom_range(0, eff - 1);
      if ($urandom_range(0, 4) != 0) begin
        it.lo = rspu_pkg::INDEX_W'((a < b) ? a : b);
        it.hi = rspu_pkg::INDEX_W'((a < b) ? b : a);
      end else begin
        it.lo = rspu_pkg::INDEX_W'(a);
        it.hi = rspu_pkg::INDEX_W'(b);
      end
    end
    if ($urandom_range(0, 9) == 0) it.hi = '1;
    if ($urandom_range(0, 19) == 0) it.lo = '0;
    return it;
  endfunction

  function automatic sum_item_t row(input logic k, input int lo, input int hi,
                                    input logic [rspu_pkg::DATA_W-1:0] v, input bit typed,
                                    input logic [rspu_pkg::DATA_W-1:0] want);
    sum_item_t it;
    it.kind  = k;
    it.lo    = rspu_pkg::INDEX_W'(lo);
    it.hi    = rspu_pkg::INDEX_W'(hi);
    it.value = v;
    it.typed = typed;
    it.want  = want;
    return it;
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_item(input sum_item_t it);
    logic [rspu_pkg::DATA_W-1:0] predicted;
    start      <= 1'b1;
    kind       <= it.kind;
    index_low  <= it.lo;
    index_high <= it.hi;
    new_value  <= it.value;
    do @(posedge clk); while (busy !== 1'b0);
    if (tree_apply(it, predicted))
      pending_sums.push_back(it.typed ? it.want : predicted);
  endtask

  // stop sending, let every result out, then let a trailing update finish
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_element_count(input logic [rspu_pkg::COUNT_W-1:0] v);
    cfg_element_count <= v;
    cfg_valid         <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    model_count = v;
  endtask

  // result checker: the receiver cannot stall, so every strobe is taken
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (pending_sums.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected result: range_sum %h at %0t", range_sum, $realtime);
        fail_count <= fail_count + 1;
      end else begin
        if (range_sum !== pending_sums[0]) begin
          if (fail_count < MAX_REPORTS)
            $display("mismatch: range_sum expected %h got %h at %0t",
                     pending_sums[0], range_sum, $realtime);
          fail_count <= fail_count + 1;
        end
        void'(pending_sums.pop_front());
      end
    end
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [rspu_pkg::COUNT_W-1:0] phase_counts [8];
    int                           eff;
    int                           left;
    int                           burst;
    int                           gap;

    for (int i = 0; i < rspu_pkg::TREE_DEPTH; i++) sum_tree[i] = '0;
    model_count = rspu_pkg::COUNT_RESET;

    // directed items; answers typed in where they are plain to see
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  0, 1023, '0, 1, 64'h0));
    directed_rows.push_back(row(rspu_pkg::KIND_UPDATE, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_UPDATE, 1023, 0, 64'h8000_0000_0000_0000,
                                0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  0, 0, '0, 1, 64'h7FFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  1023, 1023, '0, 1,
                                64'h8000_0000_0000_0000));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  0, 1023, '0, 1,
                                64'hFFFF_FFFF_FFFF_FFFF));
    // wrap past the largest positive sum
    directed_rows.push_back(row(rspu_pkg::KIND_UPDATE, 1, 0, 64'h1, 0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  0, 1, '0, 1, 64'h8000_0000_0000_0000));
    // empty span
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  5, 3, '0, 1, 64'h0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  1000, 1023, '0, 1,
                                64'h8000_0000_0000_0000));
    directed_rows.push_back(row(rspu_pkg::KIND_UPDATE, 512, 0, 64'hFFFF_FFFF_FFFF_FFFF,
                                0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  2, 1022, '0, 1,
                                64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  0, 1023, '0, 0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_UPDATE, 0, 0, 64'h0, 0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  0, 0, '0, 1, 64'h0));
    directed_rows.push_back(row(rspu_pkg::KIND_UPDATE, 1023, 0, 64'hA5A5_A5A5_5A5A_5A5A,
                                0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_UPDATE, 511, 0, 64'h0123_4567_89AB_CDEF,
                                0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  511, 512, '0, 0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  3, 1023, '0, 0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  1023, 0, '0, 1, 64'h0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  1023, 1023, '0, 0, '0));
    // fields that the operation does not use carry junk
    directed_rows.push_back(row(rspu_pkg::KIND_UPDATE, 7, 1023, 64'hFFFF_FFFF_FFFF_FFFB,
                                0, '0));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  7, 7, 64'hFFFF_FFFF_FFFF_FFFF, 1,
                                64'hFFFF_FFFF_FFFF_FFFB));
    directed_rows.push_back(row(rspu_pkg::KIND_QUERY,  0, 1023, 64'h8000_0000_0000_0000,
                                0, '0));

    // counts per random phase: one, zero, above the leaf count, the full leaf count, odd and random sizes
    phase_counts[0] = rspu_pkg::COUNT_W'(1);
    phase_counts[1] = rspu_pkg::COUNT_W'(0);
    phase_counts[2] = rspu_pkg::COUNT_W'(2047);
    phase_counts[3] = rspu_pkg::COUNT_W'(1024);
    phase_counts[4] = rspu_pkg::COUNT_W'(37);
    phase_counts[5] = rspu_pkg::COUNT_W'($urandom_range(2, 1023));
    phase_counts[6] = rspu_pkg::COUNT_W'(513);
    phase_counts[7] = rspu_pkg::COUNT_W'(1024);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // the block clears its store after reset with busy held high
    do @(posedge clk); while (busy !== 1'b0);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
      // break the back-to-back run now and then
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    wait_idle();

    foreach (phase_counts[p]) begin
      write_element_count(phase_counts[p]);
      eff  = (model_count > rspu_pkg::LEAF_COUNT) ? rspu_pkg::LEAF_COUNT
                                                  : int'(model_count);
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        while (burst > 0 && left > 0) begin
          send_item(random_item(eff));
          burst--;
          left--;
        end
        // gap between bursts, none at all in about a quarter of cases
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if ($urandom_range(0, 24) == 0) begin
          wait_idle();
        end else if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      wait_idle();
    end

    if (fail_count == 0 && pending_sums.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rspu_pkg.sv
sv/rspu_ram.sv
sv/range_sum_point_update_tree_top.sv
sim/testbench.sv
